/* hdl/assert_macros.svh */
// Concurrent assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition always brings a consequence in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* hdl/lgs_pkg.sv */
package lgs_pkg;

    localparam int SCAN_RAYS_DEFAULT = 240;
    localparam int QUEUE_DEPTH       = 4;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DANGER         = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WARNING        = 2'd3;

    localparam logic [14:0] OPEN_THRESHOLD_RST = 15'd2000;
    localparam logic [7:0]  MIN_GAP_RST        = 8'd80;
    localparam logic [13:0] DANGER_RST         = 14'd244;
    localparam logic [13:0] WARNING_RST        = 14'd739;

    localparam logic signed [12:0] US_RIGHT_BASE = 13'sd400;
    localparam logic signed [12:0] US_WHEEL      = 13'sd1000;
    localparam logic signed [12:0] US_RIGHT_INF  = -13'sd2;
    localparam logic signed [12:0] US_LEFT_FLOOR = -13'sd2048;

    localparam int              ANGLE_CENTER = 120;
    localparam logic signed [7:0] STEER_MIN   = -8'sd120;
    localparam logic signed [7:0] FORCE_RIGHT = -8'sd20;
    localparam logic signed [7:0] FORCE_LEFT  = 8'sd20;
    localparam logic [7:0]        QUOT_MAX    = 8'd120;

    typedef enum logic [1:0] {
        ZONE_CLEAR,
        ZONE_WARNING,
        ZONE_DANGER
    } zone_t;

    typedef enum logic [1:0] {
        CMD_RAY,
        CMD_RIGHT,
        CMD_LEFT
    } cmd_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ANGLE,
        ST_SIDE,
        ST_DIV,
        ST_FINISH
    } back_state_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic               open;
        logic               last;
        logic signed [11:0] dist_cm;
    } cmd_t;

    typedef struct packed {
        logic [14:0] open_threshold;
        logic [7:0]  min_gap;
        logic [13:0] danger;
        logic [13:0] warning;
    } cfg_t;

    typedef struct packed {
        logic [1:0]        left_zone;
        logic [1:0]        right_zone;
        logic [7:0]        gap_length;
        logic [7:0]        gap_start;
        logic              gap_found;
        logic signed [7:0] steer;
    } result_t;

endpackage

/* hdl/lgs_front.sv */
module lgs_front
(
    input  logic               func,
    input  logic [14:0]        range_mm,
    input  logic               range_infinite,
    input  logic               last_ray,
    input  logic signed [12:0] reading,
    input  logic [14:0]        open_threshold,
    output lgs_pkg::cmd_t      cmd,
    output logic               keep
);

    logic signed [12:0] right_diff;

    assign right_diff = reading - lgs_pkg::US_RIGHT_BASE;

    always_comb
    begin
        cmd.kind    = lgs_pkg::CMD_RAY;
        cmd.open    = range_infinite || (range_mm >= open_threshold);
        cmd.last    = last_ray;
        cmd.dist_cm = 12'sd0;
        keep        = 1'b1;
        if (func)
        begin
            cmd.open = 1'b0;
            cmd.last = 1'b0;
            if (reading > lgs_pkg::US_RIGHT_BASE && reading < lgs_pkg::US_WHEEL)
            begin
                cmd.kind    = lgs_pkg::CMD_RIGHT;
                cmd.dist_cm = right_diff[11:0];
            end
            else if (reading > lgs_pkg::US_WHEEL)
            begin
                // wheel angle: drop
                keep = 1'b0;
            end
            else if (reading == lgs_pkg::US_RIGHT_INF)
            begin
                cmd.kind    = lgs_pkg::CMD_RIGHT;
                cmd.dist_cm = reading[11:0];
            end
            else
            begin
                cmd.kind    = lgs_pkg::CMD_LEFT;
                cmd.dist_cm = (reading < lgs_pkg::US_LEFT_FLOOR) ?
                              lgs_pkg::US_LEFT_FLOOR[11:0] : reading[11:0];
            end
        end
    end

endmodule

/* hdl/lgs_queue.sv */
`include "assert_macros.svh"

module lgs_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  lgs_pkg::cmd_t push_data,
    input  logic          pop,
    output lgs_pkg::cmd_t head,
    output logic          full,
    output logic          empty
);

    localparam int DEPTH = lgs_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lgs_pkg::cmd_t    entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    `ASSERT_CLK(a_count_bound, clk, rst_n, count_reg <= CNT_W'(DEPTH), "queue overfilled")
    `ASSERT_IMPLY(a_no_pop_empty, clk, rst_n, pop, !empty, "pop from empty queue")
    `ASSERT_IMPLY(a_ptr_gap, clk, rst_n, empty || full, wr_ptr_reg == rd_ptr_reg,
                  "queue pointers out of step")

endmodule

/* hdl/lgs_back.sv */
`include "assert_macros.svh"

module lgs_back
#(
    parameter int SCAN_RAYS = lgs_pkg::SCAN_RAYS_DEFAULT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  lgs_pkg::cfg_t    cfg,
    input  lgs_pkg::cmd_t    cmd,
    input  logic             cmd_valid,
    output logic             cmd_pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output lgs_pkg::result_t result
);

    localparam int POS_W = $clog2(SCAN_RAYS);
    localparam int CNT_W = $clog2(SCAN_RAYS + 1);
    localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;
    localparam int SUM_W = CNT_W + 1;
    localparam int AW    = (SUM_W + 2 > 9) ? SUM_W + 2 : 9;
    localparam int PW    = 21;

    localparam logic [POS_W-1:0]    POS_MAX     = POS_W'(SCAN_RAYS - 1);
    localparam logic [CNT_W-1:0]    CNT_MAX     = CNT_W'(SCAN_RAYS);
    localparam logic signed [AW-1:0] ANGLE_FLOOR = -AW'(lgs_pkg::ANGLE_CENTER);

    lgs_pkg::back_state_t state_reg;
    lgs_pkg::back_state_t state_next;

    logic [POS_W-1:0]   pos_reg,        pos_next;
    logic               in_run_reg,     in_run_next;
    logic [POS_W-1:0]   run_begin_reg,  run_begin_next;
    logic [CNT_W-1:0]   run_count_reg,  run_count_next;
    logic               best_valid_reg, best_valid_next;
    logic [POS_W-1:0]   best_begin_reg, best_begin_next;
    logic [CNT_W-1:0]   best_count_reg, best_count_next;
    logic signed [11:0] right_dist_reg, right_dist_next;
    logic signed [11:0] left_dist_reg,  left_dist_next;
    logic               fin_valid_reg,  fin_valid_next;
    logic [POS_W-1:0]   fin_begin_reg,  fin_begin_next;
    logic [CNT_W-1:0]   fin_count_reg,  fin_count_next;
    logic signed [7:0]  angle_reg,      angle_next;
    lgs_pkg::zone_t     rz_reg,         rz_next;
    lgs_pkg::zone_t     lz_reg,         lz_next;
    logic               side_reg,       side_next;
    logic [PW-1:0]      prod_reg,       prod_next;
    logic               neg_reg,        neg_next;
    logic [2:0]         k_reg,          k_next;
    logic [7:0]         q_reg,          q_next;
    logic               m_valid_reg,    m_valid_next;
    lgs_pkg::result_t   out_reg,        out_next;

    logic               step_in_run;
    logic [POS_W-1:0]   step_begin;
    logic [CNT_W-1:0]   step_count;
    logic               step_bv;
    logic [POS_W-1:0]   step_bb;
    logic [CNT_W-1:0]   step_bc;
    logic               close_valid;
    logic [POS_W-1:0]   close_begin;
    logic [CNT_W-1:0]   close_count;

    logic [SUM_W-1:0]   center;
    logic signed [AW-1:0] angle_wide;
    logic signed [7:0]  angle_base;
    lgs_pkg::zone_t     side_zone;
    logic signed [11:0] side_dist;
    logic signed [15:0] side_ten;
    logic [7:0]         angle_abs;
    logic [PW-1:0]      div_shift;
    logic               div_ge;
    logic [7:0]         q_final;
    logic               out_free;

    function automatic lgs_pkg::zone_t zone_of(input logic signed [11:0] d,
                                               input logic [13:0] danger,
                                               input logic [13:0] warning);
        logic signed [15:0] t;
        logic signed [15:0] dn;
        logic signed [15:0] wn;
        lgs_pkg::zone_t     z;
        t  = 16'(d) * 16'sd10;
        dn = $signed({2'b00, danger});
        wn = $signed({2'b00, warning});
        if (d > 12'sd0 && t <= dn)
        begin
            z = lgs_pkg::ZONE_DANGER;
        end
        else if (t > dn && t <= wn)
        begin
            z = lgs_pkg::ZONE_WARNING;
        end
        else
        begin
            z = lgs_pkg::ZONE_CLEAR;
        end
        return z;
    endfunction

    // ray step: run tracking, then close at the last ray
    always_comb
    begin
        step_in_run = in_run_reg;
        step_begin  = run_begin_reg;
        step_count  = run_count_reg;
        step_bv     = best_valid_reg;
        step_bb     = best_begin_reg;
        step_bc     = best_count_reg;
        if (cmd.open)
        begin
            if (!in_run_reg)
            begin
                step_in_run = 1'b1;
                step_begin  = pos_reg;
                step_count  = CNT_W'(1);
            end
            else if (run_count_reg < CNT_MAX)
            begin
                step_count = run_count_reg + 1'b1;
            end
        end
        else
        begin
            if (in_run_reg && CMP_W'(run_count_reg) >= CMP_W'(cfg.min_gap))
            begin
                step_bv = 1'b1;
                step_bb = run_begin_reg;
                step_bc = run_count_reg;
            end
            step_in_run = 1'b0;
        end
        close_valid = step_bv;
        close_begin = step_bb;
        close_count = step_bc;
        if (step_in_run && CMP_W'(step_count) >= CMP_W'(cfg.min_gap))
        begin
            close_valid = 1'b1;
            close_begin = step_begin;
            close_count = step_count;
        end
    end

    always_comb
    begin
        center     = SUM_W'(fin_begin_reg) + SUM_W'(fin_count_reg >> 1);
        angle_wide = AW'(lgs_pkg::ANGLE_CENTER) - $signed(AW'(center));
        if (!fin_valid_reg)
        begin
            angle_base = 8'sd0;
        end
        else if (angle_wide < ANGLE_FLOOR)
        begin
            angle_base = lgs_pkg::STEER_MIN;
        end
        else
        begin
            angle_base = angle_wide[7:0];
        end
        side_zone = side_reg ? lz_reg : rz_reg;
        side_dist = side_reg ? left_dist_reg : right_dist_reg;
        side_ten  = 16'(side_dist) * 16'sd10;
        angle_abs = angle_reg[7] ? 8'(-angle_reg) : angle_reg;
        div_shift = PW'(cfg.warning) << k_reg;
        div_ge    = (prod_reg >= div_shift);
        q_final   = q_reg | (8'(div_ge) << k_reg);
        out_free  = !m_valid_reg || m_tready;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lgs_pkg::ST_IDLE:
            begin
                if (cmd_valid && cmd.kind == lgs_pkg::CMD_RAY && cmd.last)
                begin
                    state_next = lgs_pkg::ST_ANGLE;
                end
            end
            lgs_pkg::ST_ANGLE:
            begin
                state_next = lgs_pkg::ST_SIDE;
            end
            lgs_pkg::ST_SIDE:
            begin
                if (side_zone == lgs_pkg::ZONE_WARNING)
                begin
                    state_next = lgs_pkg::ST_DIV;
                end
                else if (side_reg)
                begin
                    state_next = lgs_pkg::ST_FINISH;
                end
            end
            lgs_pkg::ST_DIV:
            begin
                if (k_reg == 3'd0)
                begin
                    state_next = side_reg ? lgs_pkg::ST_FINISH : lgs_pkg::ST_SIDE;
                end
            end
            lgs_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = lgs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lgs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pos_next        = pos_reg;
        in_run_next     = in_run_reg;
        run_begin_next  = run_begin_reg;
        run_count_next  = run_count_reg;
        best_valid_next = best_valid_reg;
        best_begin_next = best_begin_reg;
        best_count_next = best_count_reg;
        right_dist_next = right_dist_reg;
        left_dist_next  = left_dist_reg;
        fin_valid_next  = fin_valid_reg;
        fin_begin_next  = fin_begin_reg;
        fin_count_next  = fin_count_reg;
        angle_next      = angle_reg;
        rz_next         = rz_reg;
        lz_next         = lz_reg;
        side_next       = side_reg;
        prod_next       = prod_reg;
        neg_next        = neg_reg;
        k_next          = k_reg;
        q_next          = q_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        out_next        = out_reg;
        case (state_reg)
            lgs_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.kind)
                        lgs_pkg::CMD_RAY:
                        begin
                            if (cmd.last)
                            begin
                                fin_valid_next  = close_valid;
                                fin_begin_next  = close_valid ? close_begin : '0;
                                fin_count_next  = close_valid ? close_count : '0;
                                pos_next        = '0;
                                in_run_next     = 1'b0;
                                run_begin_next  = '0;
                                run_count_next  = '0;
                                best_valid_next = 1'b0;
                                best_begin_next = '0;
                                best_count_next = '0;
                                side_next       = 1'b0;
                            end
                            else
                            begin
                                pos_next        = (pos_reg < POS_MAX) ? pos_reg + 1'b1 : pos_reg;
                                in_run_next     = step_in_run;
                                run_begin_next  = step_begin;
                                run_count_next  = step_count;
                                best_valid_next = step_bv;
                                best_begin_next = step_bb;
                                best_count_next = step_bc;
                            end
                        end
                        lgs_pkg::CMD_RIGHT:
                        begin
                            right_dist_next = cmd.dist_cm;
                        end
                        lgs_pkg::CMD_LEFT:
                        begin
                            left_dist_next = cmd.dist_cm;
                        end
                        default:
                        begin
                            pos_next = pos_reg;
                        end
                    endcase
                end
            end
            lgs_pkg::ST_ANGLE:
            begin
                angle_next = angle_base;
                rz_next    = zone_of(right_dist_reg, cfg.danger, cfg.warning);
                lz_next    = zone_of(left_dist_reg, cfg.danger, cfg.warning);
            end
            lgs_pkg::ST_SIDE:
            begin
                case (side_zone)
                    lgs_pkg::ZONE_DANGER:
                    begin
                        angle_next = side_reg ? lgs_pkg::FORCE_LEFT : lgs_pkg::FORCE_RIGHT;
                        side_next  = 1'b1;
                    end
                    lgs_pkg::ZONE_WARNING:
                    begin
                        prod_next = PW'(angle_abs[6:0]) * PW'(side_ten[13:0]);
                        neg_next  = angle_reg[7];
                        k_next    = 3'd7;
                        q_next    = 8'd0;
                    end
                    default:
                    begin
                        side_next = 1'b1;
                    end
                endcase
            end
            lgs_pkg::ST_DIV:
            begin
                prod_next = div_ge ? prod_reg - div_shift : prod_reg;
                q_next    = q_final;
                k_next    = k_reg - 1'b1;
                if (k_reg == 3'd0)
                begin
                    angle_next = neg_reg ? $signed(8'd0 - q_final) : $signed(q_final);
                    side_next  = 1'b1;
                end
            end
            lgs_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    m_valid_next        = 1'b1;
                    out_next.steer      = angle_reg;
                    out_next.gap_found  = fin_valid_reg;
                    out_next.gap_start  = fin_valid_reg ? 8'(fin_begin_reg) : 8'd0;
                    out_next.gap_length = fin_valid_reg ? 8'(fin_count_reg) : 8'd0;
                    out_next.right_zone = rz_reg;
                    out_next.left_zone  = lz_reg;
                end
            end
            default:
            begin
                m_valid_next = m_valid_reg && !m_tready;
            end
        endcase
    end

    always_comb
    begin
        cmd_pop  = (state_reg == lgs_pkg::ST_IDLE) && cmd_valid;
        m_tvalid = m_valid_reg;
        result   = out_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= lgs_pkg::ST_IDLE;
            pos_reg        <= '0;
            in_run_reg     <= 1'b0;
            run_begin_reg  <= '0;
            run_count_reg  <= '0;
            best_valid_reg <= 1'b0;
            best_begin_reg <= '0;
            best_count_reg <= '0;
            right_dist_reg <= '0;
            left_dist_reg  <= '0;
            side_reg       <= 1'b0;
            k_reg          <= '0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            in_run_reg     <= in_run_next;
            run_begin_reg  <= run_begin_next;
            run_count_reg  <= run_count_next;
            best_valid_reg <= best_valid_next;
            best_begin_reg <= best_begin_next;
            best_count_reg <= best_count_next;
            right_dist_reg <= right_dist_next;
            left_dist_reg  <= left_dist_next;
            side_reg       <= side_next;
            k_reg          <= k_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fin_valid_reg <= fin_valid_next;
        fin_begin_reg <= fin_begin_next;
        fin_count_reg <= fin_count_next;
        angle_reg     <= angle_next;
        rz_reg        <= rz_next;
        lz_reg        <= lz_next;
        prod_reg      <= prod_next;
        neg_reg       <= neg_next;
        q_reg         <= q_next;
        out_reg       <= out_next;
    end

    `ASSERT_IMPLY(a_quot_range, clk, rst_n, state_reg == lgs_pkg::ST_DIV && k_reg == 3'd0,
                  q_final <= lgs_pkg::QUOT_MAX, "scaled angle exceeds input angle")
    `ASSERT_IMPLY(a_load_from_finish, clk, rst_n, $rose(m_valid_reg),
                  $past(state_reg) == lgs_pkg::ST_FINISH, "result loaded outside finish")
    `ASSERT_IMPLY(a_scan_cleared, clk, rst_n, state_reg == lgs_pkg::ST_ANGLE,
                  pos_reg == '0 && !in_run_reg && !best_valid_reg, "scan state not cleared")
    `ASSERT_IMPLY(a_no_gap_zero, clk, rst_n, m_valid_reg && !out_reg.gap_found,
                  out_reg.gap_start == 8'd0 && out_reg.gap_length == 8'd0,
                  "gap fields set without a gap")

endmodule

/* hdl/lidar_gap_steering_core.sv */
// Follow-the-gap steering core: a front end takes one item per cycle while the queue
// is not full, drops wheel-angle readings and turns rays and ultrasonic readings into
// commands for a 4-entry queue; the back end retires a ray or an ultrasonic update in
// its idle state. A ray marked last passes the angle, side and finish states, and the
// divide state for each side in its warning zone, run by the 8-step shift-subtract divider
// shared by both sides; the queue keeps taking items during that time until it fills. One
// result per scan leaves through a registered output that holds while the sink stalls.
module lidar_gap_steering_core
#(
    parameter int SCAN_RAYS = lgs_pkg::SCAN_RAYS_DEFAULT
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [31:0]                    s_tdata,   // range_mm, range_infinite, reading
    input  logic                           s_tuser,   // func
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // steer_quarter_deg, gap_found, gap_start, gap_length, right_zone, left_zone
    output logic [31:0]                    m_tdata,
    input  logic                           cfg_we,
    input  logic [lgs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lgs_pkg::CFG_DATA_W-1:0] cfg_data
);

    lgs_pkg::cfg_t    cfg_reg;
    lgs_pkg::cfg_t    cfg_next;
    lgs_pkg::cmd_t    front_cmd;
    logic             front_keep;
    lgs_pkg::cmd_t    queue_head;
    logic             queue_full;
    logic             queue_empty;
    logic             queue_push;
    logic             queue_pop;
    lgs_pkg::result_t result;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                lgs_pkg::CFG_OPEN_THRESHOLD: cfg_next.open_threshold = cfg_data[14:0];
                lgs_pkg::CFG_MIN_GAP:        cfg_next.min_gap        = cfg_data[7:0];
                lgs_pkg::CFG_DANGER:         cfg_next.danger         = cfg_data[13:0];
                lgs_pkg::CFG_WARNING:        cfg_next.warning        = cfg_data[13:0];
                default:                     cfg_next                = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.open_threshold <= lgs_pkg::OPEN_THRESHOLD_RST;
            cfg_reg.min_gap        <= lgs_pkg::MIN_GAP_RST;
            cfg_reg.danger         <= lgs_pkg::DANGER_RST;
            cfg_reg.warning        <= lgs_pkg::WARNING_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign s_tready   = !queue_full;
    assign queue_push = s_tvalid && s_tready && front_keep;

    lgs_front u_front
    (
        .func           (s_tuser),
        .range_mm       (s_tdata[14:0]),
        .range_infinite (s_tdata[15]),
        .last_ray       (s_tlast),
        .reading        ($signed(s_tdata[28:16])),
        .open_threshold (cfg_reg.open_threshold),
        .cmd            (front_cmd),
        .keep           (front_keep)
    );

    lgs_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (queue_push),
        .push_data (front_cmd),
        .pop       (queue_pop),
        .head      (queue_head),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    lgs_back
    #(
        .SCAN_RAYS (SCAN_RAYS)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd       (queue_head),
        .cmd_valid (!queue_empty),
        .cmd_pop   (queue_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .result    (result)
    );

    assign m_tdata = {3'b000, result};

endmodule
